/* src/tcw_pkg.sv */
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int DEF_COLUMNS     = 80;
  localparam int DEF_ROWS        = 25;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam int FUNC_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int POS_W      = 11;
  localparam int CELL_W     = 16;
  localparam int ATTR_W     = 8;
  localparam int TAB_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTRIBUTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH = 1'b1;

  localparam logic [ATTR_W-1:0] RESET_ATTRIBUTE = 8'h07;
  localparam logic [TAB_W-1:0]  RESET_TAB_WIDTH = 7'd4;

  // function codes on the request channel
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // byte codes
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LAST      = 8'h7F;

  localparam logic [CELL_W-1:0] RESET_BLANK_CELL = {RESET_ATTRIBUTE, CHAR_BLANK};

  // classified operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE      = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE     = 3'd1;
  localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd2;
  localparam logic [OP_W-1:0] OP_TAB       = 3'd3;
  localparam logic [OP_W-1:0] OP_RETURN    = 3'd4;
  localparam logic [OP_W-1:0] OP_NEWLINE   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd6;
  localparam logic [OP_W-1:0] OP_READ      = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } item_t;

endpackage

/* src/text_console_writer_top.sv */
`timescale 1ns / 1ps

// Put, read and no-op transactions pass the classify register and the queue, then move
// from the queue head through the idle and finish states into the result register.
// A put that scrolls adds a copy pass that moves the rows up and a fill pass that blanks
// the last row; a clear fills the whole screen. The screen memory has a single write port.
// The back end pops a new transaction only after the last one has loaded its result.
// Reset: a pass over all ROWS*COLUMNS cells blanks the screen; req_ready stays low.
module text_console_writer_top #(
  parameter int COLUMNS     = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS        = tcw_pkg::DEF_ROWS,
  parameter int QUEUE_DEPTH = tcw_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [tcw_pkg::FUNC_W-1:0]     func,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::IDX_W-1:0]      cell_index,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [tcw_pkg::POS_W-1:0]      cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]     cell_data,
  output logic                           scrolled
);

  logic           init_busy;
  logic           push_valid;
  logic           push_ready;
  tcw_pkg::item_t push_item;
  logic           q_valid;
  logic           q_pop;
  tcw_pkg::item_t q_item;

  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (init_busy),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .func       (func),
    .char_code  (char_code),
    .cell_index (cell_index),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  tcw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .init_busy       (init_busy),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .cursor_position (cursor_position),
    .cell_data       (cell_data),
    .scrolled        (scrolled)
  );

endmodule

/* src/tcw_front.sv */
`timescale 1ns / 1ps

module tcw_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        hold,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [tcw_pkg::FUNC_W-1:0]  func,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcw_pkg::IDX_W-1:0]   cell_index,
  output logic                        push_valid,
  input  logic                        push_ready,
  output tcw_pkg::item_t              push_item
);

  logic           item_valid;
  tcw_pkg::item_t item;
  tcw_pkg::item_t decoded;

  always_comb begin
    decoded.ch  = char_code;
    decoded.idx = cell_index;
    case (func)
      tcw_pkg::FUNC_PUT: begin
        case (char_code)
          tcw_pkg::CHAR_BACKSPACE: decoded.op = tcw_pkg::OP_BACKSPACE;
          tcw_pkg::CHAR_TAB:       decoded.op = tcw_pkg::OP_TAB;
          tcw_pkg::CHAR_RETURN:    decoded.op = tcw_pkg::OP_RETURN;
          tcw_pkg::CHAR_NEWLINE:   decoded.op = tcw_pkg::OP_NEWLINE;
          default: begin
            if (char_code >= tcw_pkg::CHAR_BLANK && char_code <= tcw_pkg::CHAR_LAST) begin
              decoded.op = tcw_pkg::OP_WRITE;
            end else begin
              decoded.op = tcw_pkg::OP_NONE;
            end
          end
        endcase
      end
      tcw_pkg::FUNC_CLEAR: decoded.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::FUNC_READ:  decoded.op = tcw_pkg::OP_READ;
      default:             decoded.op = tcw_pkg::OP_NONE;
    endcase
  end

  assign req_ready  = !hold && (!item_valid || push_ready);
  assign push_valid = item_valid;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      item_valid <= 1'b1;
    end else if (push_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= decoded;
    end
  end

endmodule

/* src/tcw_queue.sv */
`timescale 1ns / 1ps

module tcw_queue #(
  parameter int DEPTH = tcw_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  tcw_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop,
  output tcw_pkg::item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tcw_pkg::item_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

/* src/tcw_back.sv */
`timescale 1ns / 1ps

module tcw_back #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           q_valid,
  input  tcw_pkg::item_t                 q_item,
  output logic                           q_pop,
  output logic                           init_busy,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [tcw_pkg::POS_W-1:0]      cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]     cell_data,
  output logic                           scrolled
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
  localparam int AW         = $clog2(CELLS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int SUM_W      = ((COL_W > tcw_pkg::TAB_W) ? COL_W : tcw_pkg::TAB_W) + 1;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_COPY   = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]                      state;
  logic [COL_W-1:0]                col;
  logic [ROW_W-1:0]                row;
  logic [AW-1:0]                   cnt;
  logic                            cp_pend;
  logic [AW-1:0]                   cp_addr;
  logic [tcw_pkg::CELL_W-1:0]      fill_data;
  logic                            rd_hit;
  logic                            scroll_flag;
  logic [tcw_pkg::ATTR_W-1:0]      attribute;
  logic [tcw_pkg::TAB_W-1:0]       tab_width;
  logic [tcw_pkg::CELL_W-1:0]      rd_data;
  logic [tcw_pkg::CELL_W-1:0]      mem [CELLS];

  logic [AW-1:0]                   cur_addr;
  logic [SUM_W-1:0]                col_sum;
  logic [ROW_W:0]                  row_sum;
  logic                            need_scroll;
  logic [COL_W-1:0]                col_new;
  logic [ROW_W-1:0]                row_new;
  logic                            in_range;
  logic [tcw_pkg::CELL_W-1:0]      blank;
  logic                            we;
  logic [AW-1:0]                   wa;
  logic [tcw_pkg::CELL_W-1:0]      wd;
  logic                            rd_en;
  logic [AW-1:0]                   ra;
  logic                            load;

  assign cur_addr  = AW'(row) * AW'(COLUMNS) + AW'(col);
  assign in_range  = 32'(q_item.idx) < 32'(CELLS);
  assign blank     = {attribute, tcw_pkg::CHAR_BLANK};
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign init_busy = state == S_INIT;
  assign load      = (state == S_FINISH) && (!rsp_valid || rsp_ready);

  // next cursor for a put operation
  always_comb begin
    col_sum = SUM_W'(col);
    row_sum = {1'b0, row};
    case (q_item.op)
      tcw_pkg::OP_WRITE: col_sum = SUM_W'(col) + SUM_W'(1);
      tcw_pkg::OP_BACKSPACE: begin
        if (col != '0) begin
          col_sum = SUM_W'(col) - SUM_W'(1);
        end
      end
      tcw_pkg::OP_TAB:    col_sum = SUM_W'(col) + SUM_W'(tab_width);
      tcw_pkg::OP_RETURN: col_sum = '0;
      tcw_pkg::OP_NEWLINE: begin
        col_sum = '0;
        row_sum = {1'b0, row} + (ROW_W + 1)'(1);
      end
      default: ;
    endcase
    // wrap past the right edge
    if (col_sum >= SUM_W'(COLUMNS)) begin
      col_sum = '0;
      row_sum = {1'b0, row} + (ROW_W + 1)'(1);
    end
    need_scroll = row_sum >= (ROW_W + 1)'(ROWS);
    col_new     = COL_W'(col_sum);
    row_new     = need_scroll ? ROW_W'(ROWS - 1) : ROW_W'(row_sum);
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    wa    = cnt;
    wd    = fill_data;
    rd_en = 1'b0;
    ra    = cnt + AW'(COLUMNS);
    case (state)
      S_INIT: begin
        we = 1'b1;
        wd = tcw_pkg::RESET_BLANK_CELL;
      end
      S_FILL: we = 1'b1;
      S_COPY: begin
        we    = cp_pend;
        wa    = cp_addr;
        wd    = rd_data;
        rd_en = cnt < AW'(COPY_CELLS);
      end
      S_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            tcw_pkg::OP_WRITE: begin
              we = 1'b1;
              wa = cur_addr;
              wd = {attribute, q_item.ch};
            end
            tcw_pkg::OP_BACKSPACE: begin
              we = col != '0;
              wa = cur_addr - AW'(1);
              wd = blank;
            end
            tcw_pkg::OP_READ: begin
              rd_en = in_range;
              ra    = AW'(q_item.idx);
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= tcw_pkg::RESET_ATTRIBUTE;
      tab_width <= tcw_pkg::RESET_TAB_WIDTH;
    end else if (cfg_write) begin
      case (cfg_index)
        tcw_pkg::REG_ATTRIBUTE: attribute <= cfg_data;
        tcw_pkg::REG_TAB_WIDTH: tab_width <= tcw_pkg::TAB_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      cnt     <= '0;
      col     <= '0;
      row     <= '0;
      cp_pend <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          if (cnt == AW'(CELLS - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            case (q_item.op)
              tcw_pkg::OP_CLEAR: begin
                col   <= '0;
                row   <= '0;
                cnt   <= '0;
                state <= S_FILL;
              end
              tcw_pkg::OP_READ: state <= S_FINISH;
              default: begin
                col <= col_new;
                row <= row_new;
                if (need_scroll) begin
                  cnt   <= '0;
                  state <= S_COPY;
                end else begin
                  state <= S_FINISH;
                end
              end
            endcase
          end
        end
        S_COPY: begin
          // read one row ahead, write the copied cell back in the following cycle
          if (cnt < AW'(COPY_CELLS)) begin
            cnt     <= cnt + AW'(1);
            cp_pend <= 1'b1;
          end else begin
            cp_pend <= 1'b0;
            state   <= S_FILL;
          end
        end
        S_FILL: begin
          if (cnt == AW'(CELLS - 1)) begin
            state <= S_FINISH;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_FINISH: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_COPY) begin
      cp_addr <= cnt;
    end
    if (q_pop) begin
      fill_data   <= blank;
      rd_hit      <= (q_item.op == tcw_pkg::OP_READ) && in_range;
      scroll_flag <= (q_item.op != tcw_pkg::OP_READ) && (q_item.op != tcw_pkg::OP_CLEAR)
                     && need_scroll;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cursor_position <= tcw_pkg::POS_W'(cur_addr);
      cell_data       <= rd_hit ? rd_data : '0;
      scrolled        <= scroll_flag;
    end
  end

  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    (32'(col) < 32'(COLUMNS)) && (32'(row) < 32'(ROWS)))
    else $error("cursor outside the screen");

  a_copy_on_last_row: assert property (@(posedge clk) disable iff (rst)
    state == S_COPY |-> row == ROW_W'(ROWS - 1))
    else $error("scroll copy running with cursor off the last row");

  a_copy_write_in_copy: assert property (@(posedge clk) disable iff (rst)
    cp_pend |-> state == S_COPY)
    else $error("pending copy write outside the copy pass");

  a_scroll_result_row: assert property (@(posedge clk) disable iff (rst)
    load && scroll_flag |=> scrolled && cursor_position == tcw_pkg::POS_W'(COPY_CELLS))
    else $error("scrolled transaction not reported at start of last row");

endmodule
